// ===== rtl/cascaded_biquad_lowpass_bank_core_macros.svh =====
// Assertion helpers for the filter bank core. They expect clk and rst in scope.
`ifndef CASCADED_BIQUAD_LOWPASS_BANK_CORE_MACROS_SVH
`define CASCADED_BIQUAD_LOWPASS_BANK_CORE_MACROS_SVH

`define CBQ_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

`define CBQ_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== rtl/cbq_pkg.sv =====
package cbq_pkg;

  localparam int CH_W           = 12;
  localparam int SAMPLE_W       = 32;
  localparam int STATE_W        = 64;
  localparam int COEF_W         = 17;
  localparam int CFG_W          = 17;
  localparam int CFG_IDX_W      = 3;
  localparam int SECTIONS_W     = 2;
  localparam int GAIN_W         = 4;
  localparam int OSHIFT_W       = 5;
  localparam int COEF_FRAC_BITS = 14;

  localparam logic [SECTIONS_W-1:0]    SECTIONS_RST     = 2'd2;
  localparam logic [GAIN_W-1:0]        GAIN_SHIFT_RST   = 4'd3;
  localparam logic signed [COEF_W-1:0] FIRST_A_RST      = 17'sd32092;
  localparam logic signed [COEF_W-1:0] FIRST_B_RST      = 17'sd15750;
  localparam logic [OSHIFT_W-1:0]      FIRST_SHIFT_RST  = 5'd5;
  localparam logic signed [COEF_W-1:0] SECOND_A_RST     = 17'sd31238;
  localparam logic signed [COEF_W-1:0] SECOND_B_RST     = 17'sd14895;
  localparam logic [OSHIFT_W-1:0]      SECOND_SHIFT_RST = 5'd12;

  typedef struct packed {
    logic [CH_W-1:0]            channel;
    logic signed [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0]            out_channel;
    logic signed [SAMPLE_W-1:0] filtered;
  } result_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SECTIONS,
    REG_GAIN_SHIFT,
    REG_FIRST_A,
    REG_FIRST_B,
    REG_FIRST_SHIFT,
    REG_SECOND_A,
    REG_SECOND_B,
    REG_SECOND_SHIFT
  } cfg_reg_t;

  typedef struct packed {
    logic ld_mul;
    logic ld_sum;
    logic ld_diff;
  } fb_ctl_t;

endpackage

// ===== rtl/cbq_ram.sv =====
module cbq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/cbq_fb.sv =====
module cbq_fb import cbq_pkg::*; (
  input  logic                      clk,
  input  fb_ctl_t                   ctl,
  input  logic [STATE_W-1:0]        older,
  input  logic [STATE_W-1:0]        newer,
  input  logic signed [COEF_W-1:0]  coef_a,
  input  logic signed [COEF_W-1:0]  coef_b,
  output logic signed [STATE_W-1:0] fb
);

  localparam int HALF  = STATE_W / 2;
  localparam int PLO_W = HALF + 1 + COEF_W;

  logic signed [HALF-1:0]    ca_ext;
  logic signed [HALF-1:0]    cb_ext;
  logic signed [PLO_W-1:0]   o_lo;
  logic signed [PLO_W-1:0]   n_lo;
  logic [HALF-1:0]           o_hi;
  logic [HALF-1:0]           n_hi;
  logic [STATE_W-1:0]        o_prod;
  logic [STATE_W-1:0]        n_prod;
  logic signed [STATE_W-1:0] diff;

  assign ca_ext = HALF'(coef_a);
  assign cb_ext = HALF'(coef_b);
  assign diff   = o_prod - n_prod;

  // Each 64-bit product is split into a full low-half product and the low
  // 32 bits of the high-half product, then recombined modulo 2^64.
  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      o_lo <= $signed({1'b0, older[HALF-1:0]}) * coef_b;
      o_hi <= older[STATE_W-1:HALF] * cb_ext;
      n_lo <= $signed({1'b0, newer[HALF-1:0]}) * coef_a;
      n_hi <= newer[STATE_W-1:HALF] * ca_ext;
    end
    if (ctl.ld_sum) begin
      o_prod <= {o_hi, {HALF{1'b0}}} + STATE_W'(o_lo);
      n_prod <= {n_hi, {HALF{1'b0}}} + STATE_W'(n_lo);
    end
    if (ctl.ld_diff) begin
      fb <= diff >>> COEF_FRAC_BITS;
    end
  end

endmodule

// ===== rtl/cascaded_biquad_lowpass_bank_core.sv =====
// Multichannel low-pass filter bank: each word carries a channel and a signed
// 32-bit sample, which passes through one or two second-order sections whose
// per-channel delay words live in two synchronous RAMs, one per section.
// Words for different channels are taken one per clock unless the output
// stalls the pipeline. A word whose channel matches a word still in the
// first eight pipeline stages waits until that word has written its section
// state back. After reset a clearing pass zeroes every address of both RAMs,
// during which no word is taken; configuration writes are taken at
// any time but must only be issued while the pipeline is empty.
module cascaded_biquad_lowpass_bank_core import cbq_pkg::*; #(
  parameter int NUM_CHANNELS = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int LAST  = 10;
  localparam int WB1   = 5;
  localparam int WB2   = 8;
  localparam int RAM_W = 2 * STATE_W;

  logic [SECTIONS_W-1:0]    sections_in_use;
  logic [GAIN_W-1:0]        input_gain_shift;
  logic signed [COEF_W-1:0] first_coef_a;
  logic signed [COEF_W-1:0] first_coef_b;
  logic [OSHIFT_W-1:0]      first_out_shift;
  logic signed [COEF_W-1:0] second_coef_a;
  logic signed [COEF_W-1:0] second_coef_b;
  logic [OSHIFT_W-1:0]      second_out_shift;

  logic [LAST:1] v;
  logic [LAST:1] ld;
  logic [LAST-1:1] ok;
  logic [CH_W-1:0] ch_s [1:LAST];
  logic signed [SAMPLE_W-1:0] x_s [1:4];
  logic [STATE_W-1:0] n1_s [2:WB1];
  logic [STATE_W-1:0] on1_s [2:WB1];
  logic [STATE_W-1:0] n2_s [2:WB2];
  logic [STATE_W-1:0] on2_s [2:WB2];
  logic signed [STATE_W-1:0] c2_s [5:7];
  logic signed [SAMPLE_W-1:0] r1_s [7:9];
  logic signed [STATE_W-1:0] w1;
  logic signed [STATE_W-1:0] y1;
  logic signed [STATE_W-1:0] w2;
  logic signed [STATE_W-1:0] y2;
  logic signed [SAMPLE_W-1:0] filtered;

  logic clr_active;
  logic [AW-1:0] clr_addr;
  logic hazard;
  logic accept;
  logic chan_ok;
  logic use2;
  logic dup_flight;

  logic [RAM_W-1:0] rd1;
  logic [RAM_W-1:0] rd2;
  logic we1;
  logic we2;
  logic [AW-1:0] waddr1;
  logic [AW-1:0] waddr2;
  logic [RAM_W-1:0] wdata1;
  logic [RAM_W-1:0] wdata2;

  logic signed [STATE_W-1:0] c1;
  logic signed [STATE_W-1:0] c2;
  logic [STATE_W-1:0] xg;
  logic [STATE_W-1:0] r1g;
  logic signed [STATE_W-1:0] y1_sh;
  logic signed [STATE_W-1:0] y2_sh;
  fb_ctl_t fb_ctl;

  assign cfg_ready = 1'b1;
  assign use2      = sections_in_use[1];
  assign chan_ok   = 32'(item.channel) < NUM_CHANNELS;
  assign accept    = item_valid && item_ready;

  always_comb begin
    ld[LAST] = !v[LAST] || result_ready;
    for (int i = LAST - 1; i >= 1; i--) begin
      ld[i] = !v[i] || ld[i + 1];
    end
  end

  always_comb begin
    hazard = 1'b0;
    for (int i = 1; i <= WB2; i++) begin
      if (v[i] && ch_s[i] == item.channel) begin
        hazard = 1'b1;
      end
    end
  end

  assign item_ready = ld[1] && !hazard && !clr_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      sections_in_use  <= SECTIONS_RST;
      input_gain_shift <= GAIN_SHIFT_RST;
      first_coef_a     <= FIRST_A_RST;
      first_coef_b     <= FIRST_B_RST;
      first_out_shift  <= FIRST_SHIFT_RST;
      second_coef_a    <= SECOND_A_RST;
      second_coef_b    <= SECOND_B_RST;
      second_out_shift <= SECOND_SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SECTIONS:     sections_in_use  <= cfg_data[SECTIONS_W-1:0];
        REG_GAIN_SHIFT:   input_gain_shift <= cfg_data[GAIN_W-1:0];
        REG_FIRST_A:      first_coef_a     <= $signed(cfg_data);
        REG_FIRST_B:      first_coef_b     <= $signed(cfg_data);
        REG_FIRST_SHIFT:  first_out_shift  <= cfg_data[OSHIFT_W-1:0];
        REG_SECOND_A:     second_coef_a    <= $signed(cfg_data);
        REG_SECOND_B:     second_coef_b    <= $signed(cfg_data);
        REG_SECOND_SHIFT: second_out_shift <= cfg_data[OSHIFT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v          <= '0;
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else begin
      if (ld[1]) begin
        v[1] <= accept;
      end
      for (int i = 2; i <= LAST; i++) begin
        if (ld[i]) begin
          v[i] <= v[i - 1];
        end
      end
      if (clr_active) begin
        if (clr_addr == AW'(NUM_CHANNELS - 1)) begin
          clr_active <= 1'b0;
        end else begin
          clr_addr <= clr_addr + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      ch_s[1] <= item.channel;
      x_s[1]  <= item.sample;
      ok[1]   <= chan_ok;
    end
    for (int i = 2; i <= LAST; i++) begin
      if (ld[i]) begin
        ch_s[i] <= ch_s[i - 1];
      end
    end
    for (int i = 2; i <= LAST - 1; i++) begin
      if (ld[i]) begin
        ok[i] <= ok[i - 1];
      end
    end
    for (int i = 2; i <= 4; i++) begin
      if (ld[i]) begin
        x_s[i] <= x_s[i - 1];
      end
    end
    if (ld[2]) begin
      n1_s[2]  <= rd1[STATE_W-1:0];
      on1_s[2] <= rd1[RAM_W-1:STATE_W] + (rd1[STATE_W-1:0] << 1);
      n2_s[2]  <= rd2[STATE_W-1:0];
      on2_s[2] <= rd2[RAM_W-1:STATE_W] + (rd2[STATE_W-1:0] << 1);
    end
    for (int i = 3; i <= WB1; i++) begin
      if (ld[i]) begin
        n1_s[i]  <= n1_s[i - 1];
        on1_s[i] <= on1_s[i - 1];
      end
    end
    for (int i = 3; i <= WB2; i++) begin
      if (ld[i]) begin
        n2_s[i]  <= n2_s[i - 1];
        on2_s[i] <= on2_s[i - 1];
      end
    end
    if (ld[5]) begin
      w1      <= xg - c1;
      c2_s[5] <= c2;
    end
    for (int i = 6; i <= 7; i++) begin
      if (ld[i]) begin
        c2_s[i] <= c2_s[i - 1];
      end
    end
    if (ld[6]) begin
      y1 <= on1_s[WB1] + w1;
    end
    if (ld[7]) begin
      r1_s[7] <= y1_sh[SAMPLE_W-1:0];
    end
    for (int i = 8; i <= 9; i++) begin
      if (ld[i]) begin
        r1_s[i] <= r1_s[i - 1];
      end
    end
    if (ld[8]) begin
      w2 <= r1g - c2_s[7];
    end
    if (ld[9]) begin
      y2 <= on2_s[WB2] + w2;
    end
    if (ld[10]) begin
      if (!ok[9]) begin
        filtered <= '0;
      end else if (use2) begin
        filtered <= y2_sh[SAMPLE_W-1:0];
      end else begin
        filtered <= r1_s[9];
      end
    end
  end

  assign xg    = STATE_W'(x_s[4]) << input_gain_shift;
  assign r1g   = STATE_W'(r1_s[7]) << input_gain_shift;
  assign y1_sh = y1 >>> first_out_shift;
  assign y2_sh = y2 >>> second_out_shift;

  assign fb_ctl.ld_mul  = ld[2];
  assign fb_ctl.ld_sum  = ld[3];
  assign fb_ctl.ld_diff = ld[4];

  cbq_fb u_fb1 (
    .clk    (clk),
    .ctl    (fb_ctl),
    .older  (rd1[RAM_W-1:STATE_W]),
    .newer  (rd1[STATE_W-1:0]),
    .coef_a (first_coef_a),
    .coef_b (first_coef_b),
    .fb     (c1)
  );

  cbq_fb u_fb2 (
    .clk    (clk),
    .ctl    (fb_ctl),
    .older  (rd2[RAM_W-1:STATE_W]),
    .newer  (rd2[STATE_W-1:0]),
    .coef_a (second_coef_a),
    .coef_b (second_coef_b),
    .fb     (c2)
  );

  assign we1    = clr_active || (v[WB1] && ok[WB1] && ld[WB1 + 1]);
  assign waddr1 = clr_active ? clr_addr : AW'(ch_s[WB1]);
  assign wdata1 = clr_active ? '0 : {n1_s[WB1], w1};

  assign we2    = clr_active || (v[WB2] && ok[WB2] && use2 && ld[WB2 + 1]);
  assign waddr2 = clr_active ? clr_addr : AW'(ch_s[WB2]);
  assign wdata2 = clr_active ? '0 : {n2_s[WB2], w2};

  cbq_ram #(.WIDTH(RAM_W), .DEPTH(NUM_CHANNELS)) u_ram1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr1),
    .wdata (wdata1),
    .re    (accept),
    .raddr (AW'(item.channel)),
    .rdata (rd1)
  );

  cbq_ram #(.WIDTH(RAM_W), .DEPTH(NUM_CHANNELS)) u_ram2 (
    .clk   (clk),
    .we    (we2),
    .waddr (waddr2),
    .wdata (wdata2),
    .re    (accept),
    .raddr (AW'(item.channel)),
    .rdata (rd2)
  );

  assign result_valid       = v[LAST];
  assign result.out_channel = ch_s[LAST];
  assign result.filtered    = filtered;

  always_comb begin
    dup_flight = 1'b0;
    for (int i = 1; i <= WB2; i++) begin
      for (int j = i + 1; j <= WB2; j++) begin
        if (v[i] && v[j] && ch_s[i] == ch_s[j]) begin
          dup_flight = 1'b1;
        end
      end
    end
  end

`include "cascaded_biquad_lowpass_bank_core_macros.svh"

  `CBQ_ASSERT(a_one_word_per_channel, !dup_flight, "two words of one channel before write-back")
  `CBQ_ASSERT_IMP(a_clear_empty, clr_active, v == '0, "pipeline busy during clearing pass")
  `CBQ_ASSERT_IMP(a_clear_length, $fell(clr_active), $past(clr_addr) == AW'(NUM_CHANNELS - 1), "clearing pass ended early")

endmodule

// ===== tb/cascaded_biquad_lowpass_bank_core_tb.sv =====
module cascaded_biquad_lowpass_bank_core_tb import cbq_pkg::*;;

  localparam int NUM_CH      = 4096;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 16;
  localparam logic [CFG_W-1:0] COEF_MOST_NEG = 17'h10000;
  localparam logic [CFG_W-1:0] COEF_MOST_POS = 17'h0FFFF;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_ready;
  item_t                item         = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  result_t              result;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;

  cascaded_biquad_lowpass_bank_core #(
    .NUM_CHANNELS(NUM_CH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Filter bank copy: settings and per-channel delay words of both sections.
  logic [SECTIONS_W-1:0]    cfg_sections = SECTIONS_RST;
  logic [GAIN_W-1:0]        cfg_gain     = GAIN_SHIFT_RST;
  logic signed [COEF_W-1:0] cfg_a1       = FIRST_A_RST;
  logic signed [COEF_W-1:0] cfg_b1       = FIRST_B_RST;
  logic [OSHIFT_W-1:0]      cfg_shift1   = FIRST_SHIFT_RST;
  logic signed [COEF_W-1:0] cfg_a2       = SECOND_A_RST;
  logic signed [COEF_W-1:0] cfg_b2       = SECOND_B_RST;
  logic [OSHIFT_W-1:0]      cfg_shift2   = SECOND_SHIFT_RST;

  longint sec1_older [NUM_CH];
  longint sec1_newer [NUM_CH];
  longint sec2_older [NUM_CH];
  longint sec2_newer [NUM_CH];

  item_t   sample_words [$];
  result_t expected_filtered [$];
  result_t oldest_filtered;
  int      mismatch_count = 0;
  int      cycle_count    = 0;
  int      burst_left     = 0;
  int      gap_left       = 0;
  logic [9:0] stall_phase = '0;
  logic [SAMPLE_W-1:0] edge_samples [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                            32'h0000_0001};
  logic [CH_W-1:0]     hot_channels [6] = '{12'd0, 12'd1, 12'd2, 12'd7, 12'd2048, 12'd4095};

  // The section output is formed from the old delay words before they advance.
  function automatic logic signed [SAMPLE_W-1:0] run_section(
    input logic signed [SAMPLE_W-1:0] x,
    inout longint older,
    inout longint newer,
    input logic signed [COEF_W-1:0] ca,
    input logic signed [COEF_W-1:0] cb,
    input logic [OSHIFT_W-1:0] oshift
  );
    longint fb;
    longint w;
    longint y;
    fb = (older * longint'(cb) - newer * longint'(ca)) >>> COEF_FRAC_BITS;
    w = (longint'(x) <<< cfg_gain) - fb;
    y = older + (newer <<< 1) + w;
    older = newer;
    newer = w;
    return SAMPLE_W'(y >>> oshift);
  endfunction

  function automatic result_t filter_sample(input item_t it);
    result_t r;
    logic signed [SAMPLE_W-1:0] x;
    r.out_channel = it.channel;
    r.filtered = '0;
    if (it.channel < NUM_CH) begin
      x = run_section(it.sample, sec1_older[it.channel], sec1_newer[it.channel],
                      cfg_a1, cfg_b1, cfg_shift1);
      if (cfg_sections >= 2)
        x = run_section(x, sec2_older[it.channel], sec2_newer[it.channel],
                        cfg_a2, cfg_b2, cfg_shift2);
      r.filtered = x;
    end
    return r;
  endfunction

  function automatic item_t sample_word(input logic [CH_W-1:0] ch,
                                        input logic [SAMPLE_W-1:0] s);
    item_t it;
    it.channel = ch;
    it.sample = s;
    return it;
  endfunction

  function automatic item_t random_word();
    item_t it;
    int    kind;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 9) < 7)
      it.channel = hot_channels[$urandom_range(0, 5)];
    else
      it.channel = CH_W'($urandom_range(0, NUM_CH - 1));
    if (kind < 4)
      it.sample = $urandom;
    else if (kind < 8)
      it.sample = SAMPLE_W'($urandom_range(0, 65535) - 32768);
    else if (kind == 8)
      it.sample = edge_samples[$urandom_range(0, 3)];
    else
      it.sample = '0;
    return it;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (sample_words.size() != 0 || item_valid || expected_filtered.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic run_phase(input int count);
    repeat (count) sample_words.push_back(random_word());
    wait_drained();
  endtask

  task automatic write_defaults();
    write_reg(REG_SECTIONS, CFG_W'(SECTIONS_RST));
    write_reg(REG_GAIN_SHIFT, CFG_W'(GAIN_SHIFT_RST));
    write_reg(REG_FIRST_A, FIRST_A_RST);
    write_reg(REG_FIRST_B, FIRST_B_RST);
    write_reg(REG_FIRST_SHIFT, CFG_W'(FIRST_SHIFT_RST));
    write_reg(REG_SECOND_A, SECOND_A_RST);
    write_reg(REG_SECOND_B, SECOND_B_RST);
    write_reg(REG_SECOND_SHIFT, CFG_W'(SECOND_SHIFT_RST));
  endtask

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SECTIONS:     cfg_sections = cfg_data[SECTIONS_W-1:0];
        REG_GAIN_SHIFT:   cfg_gain     = cfg_data[GAIN_W-1:0];
        REG_FIRST_A:      cfg_a1       = cfg_data;
        REG_FIRST_B:      cfg_b1       = cfg_data;
        REG_FIRST_SHIFT:  cfg_shift1   = cfg_data[OSHIFT_W-1:0];
        REG_SECOND_A:     cfg_a2       = cfg_data;
        REG_SECOND_B:     cfg_b2       = cfg_data;
        REG_SECOND_SHIFT: cfg_shift2   = cfg_data[OSHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_ready) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        item_valid <= 1'b0;
      end else if (sample_words.size() != 0) begin
        item <= sample_words.pop_front();
        item_valid <= 1'b1;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 3) == 0) begin
            burst_left = 40;
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left = $urandom_range(1, 8);
          end
        end
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_phase[9:8])
        2'd0:    result_ready <= 1'b1;
        2'd1:    result_ready <= 1'($urandom_range(0, 1));
        2'd2:    result_ready <= (stall_phase[2:0] < 3'd3);
        default: result_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && item_valid && item_ready)
      expected_filtered.push_back(filter_sample(item));
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (expected_filtered.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected word: channel %0d filtered %0d",
                   result.out_channel, result.filtered);
      end else begin
        oldest_filtered = expected_filtered.pop_front();
        if (result.out_channel !== oldest_filtered.out_channel ||
            result.filtered !== oldest_filtered.filtered) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected channel %0d filtered %0d, got channel %0d filtered %0d",
                     oldest_filtered.out_channel, oldest_filtered.filtered,
                     result.out_channel, result.filtered);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cascaded_biquad_lowpass_bank_core regression: fail");
      $finish;
    end
  end

  initial begin
    cfg_reg_t idx;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    sample_words.push_back(sample_word(12'd0, 32'd1));
    repeat (3) sample_words.push_back(sample_word(12'd0, 32'd0));
    repeat (3) sample_words.push_back(sample_word(12'd4095, 32'h7FFF_FFFF));
    repeat (3) sample_words.push_back(sample_word(12'd4095, 32'h8000_0000));
    sample_words.push_back(sample_word(12'd1, 32'hFFFF_FFFF));
    sample_words.push_back(sample_word(12'd2, 32'h8000_0000));
    sample_words.push_back(sample_word(12'd1, 32'h7FFF_FFFF));
    sample_words.push_back(sample_word(12'd2048, 32'd1000));
    sample_words.push_back(sample_word(12'd2730, 32'h5555_5555));
    sample_words.push_back(sample_word(12'd1365, 32'hAAAA_AAAA));
    sample_words.push_back(sample_word(12'd5, 32'd12345));
    sample_words.push_back(sample_word(12'd6, -32'sd12345));
    sample_words.push_back(sample_word(12'd5, 32'd0));
    sample_words.push_back(sample_word(12'd6, 32'd0));
    wait_drained();

    write_reg(REG_SECTIONS, 17'd1);
    write_reg(REG_GAIN_SHIFT, 17'd15);
    write_reg(REG_FIRST_A, COEF_MOST_NEG);
    write_reg(REG_FIRST_B, COEF_MOST_POS);
    write_reg(REG_FIRST_SHIFT, 17'd31);
    run_phase(60);

    write_reg(REG_SECTIONS, 17'd0);
    write_reg(REG_GAIN_SHIFT, 17'd0);
    write_reg(REG_FIRST_A, COEF_MOST_POS);
    write_reg(REG_FIRST_B, COEF_MOST_NEG);
    write_reg(REG_FIRST_SHIFT, 17'd0);
    run_phase(60);

    write_reg(REG_SECTIONS, 17'd3);
    write_reg(REG_GAIN_SHIFT, 17'd7);
    write_reg(REG_FIRST_A, FIRST_A_RST);
    write_reg(REG_FIRST_B, FIRST_B_RST);
    write_reg(REG_FIRST_SHIFT, 17'd9);
    write_reg(REG_SECOND_A, COEF_MOST_NEG);
    write_reg(REG_SECOND_B, COEF_MOST_POS);
    write_reg(REG_SECOND_SHIFT, 17'd0);
    run_phase(60);

    write_defaults();
    write_reg(REG_SECOND_A, COEF_MOST_POS);
    write_reg(REG_SECOND_B, COEF_MOST_NEG);
    write_reg(REG_SECOND_SHIFT, 17'd31);
    run_phase(60);

    repeat (6) begin
      idx = idx.first();
      repeat (8) begin
        write_reg(idx, CFG_W'($urandom_range(0, 17'h1FFFF)));
        idx = idx.next();
      end
      run_phase(60);
    end

    write_defaults();
    run_phase(40);

    if (mismatch_count == 0 && expected_filtered.size() == 0)
      $display("cascaded_biquad_lowpass_bank_core regression: pass");
    else
      $display("cascaded_biquad_lowpass_bank_core regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cbq_pkg.sv
rtl/cbq_ram.sv
rtl/cbq_fb.sv
rtl/cascaded_biquad_lowpass_bank_core.sv
tb/cascaded_biquad_lowpass_bank_core_tb.sv
